// ----- rtl/core/ssrg_pkg.sv -----
package ssrg_pkg;

   // field widths
   localparam int unsigned CMD_W        = 2;
   localparam int unsigned SPEED_W      = 16;
   localparam int unsigned MAG_W        = SPEED_W + 1;
   localparam int unsigned PERIOD_W     = 21;
   localparam int unsigned MIN_PERIOD_W = 19;
   localparam int unsigned DIR_W        = 2;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam int unsigned REQ_DATA_W   = 16;
   localparam int unsigned RSP_DATA_W   = 32;

   // timing constants: tick rate in Hz, periods in ticks
   localparam int unsigned TICK_HZ        = 2000000;
   localparam int unsigned MAX_PERIOD     = 512000;
   localparam int unsigned MIN_PERIOD_RST = 100;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPEED = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_NONE     = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD_LEVEL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PERIOD    = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/stepper_step_rate_generator.sv -----
// Channel | Dir | Signals                               | Beat moves
// req     | in  | req_tvalid/tready, tdata, tuser       | one command (tick, set speed, start)
// rsp     | out | rsp_tvalid/tready, tdata              | one status per command
// csr     | in  | csr_we, csr_index, csr_wdata          | one register write
//
// Tick, start and unused commands register their result at accept.
// A nonzero set speed runs in order: the accept, the quotient bits of the
// restoring divider, then the clamp that registers the result. req_tready
// stays low meanwhile.
// Zero speed needs no divide; its result is registered at accept.
// Reset is synchronous, active high; no clearing pass.
// The result register parts the channels: a new beat is taken in the cycle
// the pending result leaves; a stalled rsp holds req_tready low.
module stepper_step_rate_generator #(
   parameter int unsigned SPEED_FRAC_BITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ssrg_pkg::REQ_DATA_W-1:0]       req_tdata,  // [15:0] speed
   input  logic [ssrg_pkg::CMD_W-1:0]            req_tuser,  // [1:0] cmd
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] step_pulse, [1] dir_level, [3:2] direction_code, [24:4] period_now,
   // [31:25] zero
   output logic [ssrg_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [ssrg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ssrg_pkg::MIN_PERIOD_W-1:0]     csr_wdata
);

   localparam int unsigned QW = ssrg_pkg::PERIOD_W + SPEED_FRAC_BITS;
   localparam int unsigned PW = ssrg_pkg::PERIOD_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic                              state_ff, state_in;
   logic [PW-1:0]                     tick_count_ff, tick_count_in;
   logic [PW-1:0]                     step_period_ff, step_period_in;
   logic                              running_ff, running_in;
   logic                              pin_level_ff, pin_level_in;
   logic [ssrg_pkg::DIR_W-1:0]        dir_state_ff, dir_state_in;
   logic                              forward_level_ff;
   logic [ssrg_pkg::MIN_PERIOD_W-1:0] min_period_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ssrg_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                              accept;
   logic                              pulse;
   logic                              load_out;
   logic                              div_start;
   logic [ssrg_pkg::MAG_W-1:0]        mag;
   logic [ssrg_pkg::SPEED_W-1:0]      speed;
   logic [PW-1:0]                     tick_next;
   logic [QW-1:0]                     quotient;
   ssrg_pkg::div_status_type          div_status;

   function automatic logic [PW-1:0] clamp_period(
      input logic [QW-1:0]                     per,
      input logic [ssrg_pkg::MIN_PERIOD_W-1:0] minp
   );
      logic [PW-1:0] res;
      if (per > QW'(ssrg_pkg::MAX_PERIOD)) begin
         res = PW'(ssrg_pkg::MAX_PERIOD);
      end else if (per < QW'(minp)) begin
         res = PW'(minp);
      end else begin
         res = per[PW-1:0];
      end
      return res;
   endfunction

   assign speed      = req_tdata[ssrg_pkg::SPEED_W-1:0];
   assign req_tready = (state_ff == ST_IDLE) && !div_status.busy
                       && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign tick_next  = tick_count_ff + PW'(1);

   // magnitude of a Q-format speed; 0x8000 gives 32768
   assign mag = speed[ssrg_pkg::SPEED_W-1]
                ? (ssrg_pkg::MAG_W'(1) << ssrg_pkg::SPEED_W) - {1'b0, speed}
                : {1'b0, speed};

   ssrg_divider #(
      .FRAC_BITS (SPEED_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (mag),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in       = state_ff;
      tick_count_in  = tick_count_ff;
      step_period_in = step_period_ff;
      running_in     = running_ff;
      pin_level_in   = pin_level_ff;
      dir_state_in   = dir_state_ff;
      pulse          = 1'b0;
      load_out       = 1'b0;
      div_start      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_out = 1'b1;
               unique case (req_tuser)
                  ssrg_pkg::CMD_TICK: begin
                     if (running_ff) begin
                        if (tick_next >= step_period_ff) begin
                           pulse         = 1'b1;
                           tick_count_in = '0;
                        end else begin
                           tick_count_in = tick_next;
                        end
                     end
                  end
                  ssrg_pkg::CMD_SPEED: begin
                     if (speed == '0) begin
                        dir_state_in   = ssrg_pkg::DIR_NONE;
                        step_period_in = clamp_period(QW'(ssrg_pkg::MAX_PERIOD),
                                                      min_period_ff);
                     end else begin
                        // pin and direction settle now; period after the divide
                        load_out  = 1'b0;
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                        if (speed[ssrg_pkg::SPEED_W-1]) begin
                           pin_level_in = forward_level_ff;
                           dir_state_in = ssrg_pkg::DIR_FORWARD;
                        end else begin
                           pin_level_in = ~forward_level_ff;
                           dir_state_in = ssrg_pkg::DIR_BACKWARD;
                        end
                     end
                  end
                  ssrg_pkg::CMD_START: begin
                     running_in = 1'b1;
                  end
                  default: begin
                     // unused code: status only
                  end
               endcase
            end
         end
         ST_DIV: begin
            // result register drained at accept, so it is free here
            if (div_status.done) begin
               step_period_in = clamp_period(quotient, min_period_ff);
               load_out       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load_out) begin
         rsp_data_in = ssrg_pkg::RSP_DATA_W'({step_period_in, dir_state_in,
                                              pin_level_in, pulse});
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_count_ff  <= '0;
         step_period_ff <= PW'(ssrg_pkg::TICK_HZ);
         running_ff     <= 1'b0;
         pin_level_ff   <= 1'b0;
         dir_state_ff   <= ssrg_pkg::DIR_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tick_count_ff  <= tick_count_in;
         step_period_ff <= step_period_in;
         running_ff     <= running_in;
         pin_level_ff   <= pin_level_in;
         dir_state_ff   <= dir_state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         forward_level_ff <= 1'b0;
         min_period_ff    <= ssrg_pkg::MIN_PERIOD_W'(ssrg_pkg::MIN_PERIOD_RST);
      end else if (csr_we) begin
         unique case (csr_index)
            ssrg_pkg::CSR_FORWARD_LEVEL: forward_level_ff <= csr_wdata[0];
            ssrg_pkg::CSR_MIN_PERIOD:    min_period_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/ssrg_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Dividend is the fixed tick rate scaled by the speed fraction bits.
module ssrg_divider #(
   parameter int unsigned FRAC_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ssrg_pkg::MAG_W-1:0]        divisor,
   output logic [ssrg_pkg::PERIOD_W+FRAC_BITS-1:0] quotient,
   output ssrg_pkg::div_status_type          status
);

   localparam int unsigned QW    = ssrg_pkg::PERIOD_W + FRAC_BITS;
   localparam int unsigned CNT_W = $clog2(QW + 1);
   localparam int unsigned REM_W = ssrg_pkg::MAG_W - 1;
   localparam logic [QW-1:0] DIVIDEND = QW'(ssrg_pkg::TICK_HZ) << FRAC_BITS;

   logic [QW-1:0]               q_ff, q_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [ssrg_pkg::MAG_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]            steps_ff, steps_in;
   logic                        done_ff, done_in;
   logic [ssrg_pkg::MAG_W-1:0]  trial;
   logic                        fits;

   assign trial = {rem_ff, q_ff[QW-1]};
   assign fits  = (trial >= div_ff);

   always_comb begin
      q_in     = q_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      steps_in = steps_ff;
      done_in  = 1'b0;
      if (start) begin
         q_in     = DIVIDEND;
         rem_in   = '0;
         div_in   = divisor;
         steps_in = CNT_W'(QW);
      end else if (steps_ff != '0) begin
         rem_in   = fits ? REM_W'(trial - div_ff) : REM_W'(trial);
         q_in     = {q_ff[QW-2:0], fits};
         steps_in = steps_ff - CNT_W'(1);
         done_in  = (steps_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff  <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = q_ff;
   assign status.busy = (steps_ff != '0);
   assign status.done = done_ff;

endmodule

// ----- rtl/core/ssrg_checker.sv -----
module ssrg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [ssrg_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [ssrg_pkg::CMD_W-1:0]       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ssrg_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic req_beat;
   logic speed_nz;
   logic speed_zero;

   assign req_beat   = req_tvalid && req_tready;
   assign speed_nz   = req_beat && (req_tuser == ssrg_pkg::CMD_SPEED)
                       && (req_tdata != '0);
   assign speed_zero = req_beat && (req_tuser == ssrg_pkg::CMD_SPEED)
                       && (req_tdata == '0);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a tick is answered in the next cycle
   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tuser == ssrg_pkg::CMD_TICK) |=> rsp_tvalid)
      else $error("tick result late");

   // zero speed answers at once with no direction
   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      speed_zero |=> rsp_tvalid && (rsp_tdata[3:2] == ssrg_pkg::DIR_NONE))
      else $error("zero speed result wrong");

   // a divide blocks input and shows no result in the following cycle
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      speed_nz |=> !req_tready && !rsp_tvalid)
      else $error("ready or result during divide");

endmodule

bind stepper_step_rate_generator ssrg_checker u_ssrg_checker (.*);
